// ===== rtl/adi_pkg.sv =====
package adi_pkg;

  localparam int AGE_W = 16;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;

  localparam logic [AGE_W-1:0] TIMEOUT_RST = 16'd2;
  localparam logic [AGE_W-1:0] BLOCK_RST   = 16'd40;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK   = 1'b1;

  // drive bit positions
  localparam int B_UP     = 0;
  localparam int B_DOWN   = 1;
  localparam int B_LEFT   = 2;
  localparam int B_RIGHT  = 3;
  localparam int B_ACTION = 4;

  typedef enum logic {
    OP_MSG  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    logic lim_right;
    logic lim_left;
    logic [4:0] cmd;
  } item_t;

  typedef struct packed {
    logic horizontal_blocked;
    logic vertical_blocked;
    logic timed_out;
    logic [4:0] drive;
  } result_t;

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    age_inc = (a == AGE_MAX) ? AGE_MAX : a + AGE_W'(1);
  endfunction

endpackage

// ===== rtl/adi_core.sv =====
module adi_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [adi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adi_pkg::AGE_W-1:0]     cfg_data,
  input  logic                          fire,
  input  adi_pkg::op_t                  op,
  input  adi_pkg::item_t                item,
  output adi_pkg::result_t              result
);
  import adi_pkg::*;

  logic [AGE_W-1:0] timeout_ticks;
  logic [AGE_W-1:0] block_ticks;
  logic [4:0]       commanded;
  logic [4:0]       applied;
  logic [AGE_W-1:0] msg_age;
  logic [AGE_W-1:0] v_age;
  logic [AGE_W-1:0] h_age;

  logic [AGE_W-1:0] msg_age_next;
  logic [AGE_W-1:0] v_age_cmp;
  logic [AGE_W-1:0] h_age_cmp;
  logic [4:0]       c_pair;
  logic [4:0]       c_to;
  logic [4:0]       c_out;
  logic             to;
  logic             vb;
  logic             hb;

  always_comb begin
    msg_age_next = age_inc(msg_age);
    c_pair = commanded;
    if (c_pair[B_LEFT] && c_pair[B_RIGHT]) begin
      c_pair[B_LEFT]  = 1'b0;
      c_pair[B_RIGHT] = 1'b0;
    end
    if (c_pair[B_UP] && c_pair[B_DOWN]) begin
      c_pair[B_UP]   = 1'b0;
      c_pair[B_DOWN] = 1'b0;
    end
    if (item.lim_left)  c_pair[B_LEFT]  = 1'b0;
    if (item.lim_right) c_pair[B_RIGHT] = 1'b0;
    to = msg_age_next > timeout_ticks;
    c_to = to ? 5'd0 : c_pair;
    v_age_cmp = |(applied[B_DOWN:B_UP] & ~c_to[B_DOWN:B_UP]) ? '0 : v_age;
    h_age_cmp = |(applied[B_RIGHT:B_LEFT] & ~c_to[B_RIGHT:B_LEFT]) ? '0 : h_age;
    vb = v_age_cmp < block_ticks;
    hb = h_age_cmp < block_ticks;
    c_out = c_to;
    if (vb) c_out[B_DOWN:B_UP]    = 2'b00;
    if (hb) c_out[B_RIGHT:B_LEFT] = 2'b00;
  end

  assign result = '{horizontal_blocked: hb, vertical_blocked: vb, timed_out: to,
                    drive: c_out};

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RST;
      block_ticks   <= BLOCK_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT: timeout_ticks <= cfg_data;
        CFG_BLOCK:   block_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      commanded <= '0;
      applied   <= '0;
      msg_age   <= AGE_MAX;
      v_age     <= '0;
      h_age     <= '0;
    end else if (fire) begin
      if (op == OP_MSG) begin
        commanded <= item.cmd;
        msg_age   <= '0;
      end else begin
        commanded <= c_out;
        applied   <= c_out;
        msg_age   <= msg_age_next;
        v_age     <= age_inc(v_age_cmp);
        h_age     <= age_inc(h_age_cmp);
      end
    end
  end

endmodule

// ===== rtl/axis_drive_interlock_top.sv =====
// Drive interlock for an up/down and left/right axis plus an action output.
// Each input word is either a command message (tuser = 0) that stores five
// commanded bits and restarts the message age, or a control tick (tuser = 1)
// that applies pair cancel, end-stop masking, message timeout and the
// per-axis reversal block, and returns one result word. Messages return
// nothing. A word is registered on input and its result is registered on
// output, so one word is taken every clock while the result side keeps up;
// a stalled result holds a tick in the input stage, which then holds s_tready low.
// Registers are written through cfg_we/cfg_index/cfg_data: index 0 is the
// timeout in ticks, index 1 the block length in ticks.
module axis_drive_interlock_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [adi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [adi_pkg::AGE_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // cmd_up, cmd_down, cmd_left, cmd_right, cmd_action, lim_left, lim_right, pad
  input  logic [7:0]                    s_tdata,
  // operation
  input  logic                          s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // drive_up, drive_down, drive_left, drive_right, drive_action, timed_out,
  // vertical_blocked, horizontal_blocked
  output logic [7:0]                    m_tdata
);
  import adi_pkg::*;

  logic    stg_valid;
  op_t     stg_op;
  item_t   stg_item;
  logic    advance;
  result_t result;

  assign advance  = stg_valid && (stg_op == OP_MSG || !m_tvalid || m_tready);
  assign s_tready = !stg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (s_tready) begin
      stg_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      stg_op   <= op_t'(s_tuser);
      stg_item <= item_t'(s_tdata[6:0]);
    end
  end

  adi_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .op        (stg_op),
    .item      (stg_item),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && stg_op == OP_TICK) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stg_op == OP_TICK) begin
      m_tdata <= result;
    end
  end

  a_no_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[B_UP] && m_tdata[B_DOWN]) && !(m_tdata[B_LEFT] && m_tdata[B_RIGHT]))
    else $error("opposing drive pair active");

  a_timeout_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[5] |-> m_tdata[4:0] == 5'd0)
    else $error("drive active after timeout");

  a_block_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[6] && (m_tdata[B_UP] || m_tdata[B_DOWN])) &&
                 !(m_tdata[7] && (m_tdata[B_LEFT] || m_tdata[B_RIGHT])))
    else $error("blocked axis driven");

  a_msg_silent: assert property (@(posedge clk) disable iff (rst)
    advance && stg_op == OP_MSG && !m_tvalid |=> !m_tvalid)
    else $error("message produced a result");

endmodule
